// ===== rtl/pis_pkg.sv =====
// Package for the interpolated percentile block.
// Holds the field widths, fixed-point constants and the sequencer state type.
// No dependencies.
package pis_pkg;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 17;

    // Q1.16 constants: one and one half.
    localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_INS_CMP = 9'b000000010,
        ST_INS_PUT = 9'b000000100,
        ST_POS     = 9'b000001000,
        ST_IDX     = 9'b000010000,
        ST_RD_HI   = 9'b000100000,
        ST_DIFF    = 9'b001000000,
        ST_MUL     = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

endpackage

// ===== rtl/percentile_interpolated_select.sv =====
// Interpolated percentile over a set of signed Q16.16 values kept sorted in memory.
// A value is written directly into an empty store or dropped by a full one; otherwise
// each stored entry larger than it is moved up one place through the single memory port.
// The final item then runs position, two reads, difference, multiply and output steps,
// waiting while the output register still holds an untaken result. Depends on pis_pkg.
// Reset (rst_n, asynchronous) clears the count, the overflow mark and the output valid.
module percentile_interpolated_select #(
    parameter int MAX_VALUES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration: percentile_fraction, Q1.16.
    input  logic                         cfg_wr_en,
    input  logic [pis_pkg::FRAC_W-1:0]   cfg_wr_data,
    // Input stream. tdata: [31:0] sample_value. tlast: last_sample.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pis_pkg::VALUE_W-1:0]  s_axis_tdata,
    input  logic                         s_axis_tlast,
    // Output stream. tdata: [31:0] percentile_value. tuser: [0] overflow_flag.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pis_pkg::VALUE_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tuser
);
    import pis_pkg::*;

    localparam int AW     = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW     = $clog2(MAX_VALUES + 1);
    localparam int PW     = FRAC_W + CW + 1;
    localparam int IW     = PW - 16;
    localparam int DIFF_W = VALUE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VALUES);

    // Sorted value store.
    logic [VALUE_W-1:0] store_mem [MAX_VALUES];
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data_reg;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [FRAC_W-1:0]         pfrac_reg;
    logic [VALUE_W-1:0]        value_reg, value_next;
    logic                      last_reg, last_next;
    logic [AW-1:0]             k_reg, k_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [FRAC_W-1:0]         frac_reg, frac_next;
    logic signed [VALUE_W-1:0] lo_reg, lo_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]        out_data_reg, out_data_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic [FRAC_W-1:0]         p_sat;
    logic [IW-1:0]             idx_raw;
    logic [IW-1:0]             idx_clamp;
    logic [PW-1:0]             base;
    logic [PW-1:0]             pos_rem;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [PROD_W-1:0]  res_wide;
    logic                      s_xfer;
    logic                      out_free;
    state_t                    after_ins;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

    // Saturate the requested fraction to one.
    assign p_sat = (pfrac_reg > FRAC_ONE) ? FRAC_ONE : pfrac_reg;

    // Index and fraction from the registered position.
    always_comb
    begin
        idx_raw = pos_reg[PW-1:16];
        if (idx_raw > IW'(count_reg - 1'b1))
            idx_clamp = IW'(count_reg - 1'b1);
        else
            idx_clamp = idx_raw;
        if (idx_clamp < IW'(1))
            idx_clamp = IW'(1);
        base    = {idx_clamp, 16'd0};
        pos_rem = pos_reg - base;
    end

    // Rounded final sum: lo + round((frac * (hi - lo)) / 65536), ties upward.
    assign rnd      = (prod_reg + PROD_W'(signed'(FRAC_HALF))) >>> 16;
    assign res_wide = PROD_W'(lo_reg) + rnd;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        frac_next      = frac_reg;
        lo_next        = lo_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = value_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;
        after_ins      = last_reg ? ST_POS : ST_IDLE;

        // The output register drains independently of the sequencer.
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    value_next = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    if (count_reg == MAX_CNT)
                    begin
                        // Store full: drop the value and mark it.
                        ovf_next   = 1'b1;
                        state_next = s_axis_tlast ? ST_POS : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = s_axis_tdata;
                        count_next = CW'(1);
                        state_next = s_axis_tlast ? ST_POS : ST_IDLE;
                    end
                    else
                    begin
                        // Start the shift from the top entry down.
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - 1'b1);
                        k_next     = AW'(count_reg);
                        count_next = count_reg + 1'b1;
                        state_next = ST_INS_CMP;
                    end
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(rd_data_reg) > $signed(value_reg))
                begin
                    // Move the larger entry up one place.
                    wr_data = rd_data_reg;
                    k_next  = k_reg - 1'b1;
                    if (k_reg == AW'(1))
                        state_next = ST_INS_PUT;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg - AW'(2);
                    end
                end
                else
                    state_next = after_ins;
            end
            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                state_next = after_ins;
            end
            ST_POS:
            begin
                pos_next   = PW'(p_sat) * PW'(count_reg) + PW'(FRAC_HALF);
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                idx_next = idx_clamp[AW-1:0];
                if (pos_reg <= base)
                    frac_next = '0;
                else if (pos_rem > PW'(FRAC_ONE))
                    frac_next = FRAC_ONE;
                else
                    frac_next = pos_rem[FRAC_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = idx_clamp[AW-1:0] - 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                lo_next    = $signed(rd_data_reg);
                // A single value has no upper neighbor.
                rd_en      = (count_reg > CW'(1));
                rd_addr    = idx_reg;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (count_reg > CW'(1))
                    diff_next = DIFF_W'($signed(rd_data_reg)) - DIFF_W'(lo_reg);
                else
                    diff_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'($signed({1'b0, frac_reg}) * diff_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_wide[VALUE_W-1:0];
                    out_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            pfrac_reg     <= FRAC_HALF;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                pfrac_reg <= cfg_wr_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        frac_reg     <= frac_next;
        lo_reg       <= lo_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

// ===== tb/sv/percentile_interpolated_select_tb.sv =====
// Testbench for percentile_interpolated_select: streams sets of Q16.16 values,
// predicts each interpolated percentile, and checks the output stream.
// Depends on pis_pkg and the percentile_interpolated_select RTL.
`timescale 1ns / 1ps

module percentile_interpolated_select_tb;

    import pis_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 300;

    // One expected output transfer.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               dropped;
    } percentile_result_t;

    // Kinds of value content used to build a set.
    typedef enum int {
        MIX_WIDE,
        MIX_CLUSTERED,
        MIX_MODERATE,
        MIX_EXTREME
    } value_mix_t;

    // Keeps a sorted copy of the current set and the expected percentiles.
    class percentile_checker_t;
        logic signed [VALUE_W-1:0] sorted_vals [STORE_DEPTH];
        int unsigned               held_count;
        bit                        dropped;
        logic [FRAC_W-1:0]         fraction;
        percentile_result_t        pending_percentiles [$];
        int unsigned               mismatches;
        int unsigned               sets_checked;
        int unsigned               overflow_sets;

        function new();
            held_count = 0;
            dropped = 1'b0;
            fraction = FRAC_HALF;
            mismatches = 0;
            sets_checked = 0;
            overflow_sets = 0;
        endfunction

        function void set_fraction(logic [FRAC_W-1:0] f);
            fraction = f;
        endfunction

        // MATLAB-style percentile over the held values, rounded half up.
        function logic signed [VALUE_W-1:0] interpolate();
            longint n;
            longint p;
            longint one_q16;
            longint half_q16;
            longint pos;
            longint idx;
            longint base;
            longint frac;
            longint lo;
            longint hi;
            longint sum;
            n = held_count;
            one_q16 = FRAC_ONE;
            half_q16 = FRAC_HALF;
            if (n <= 1)
                return sorted_vals[0];
            p = fraction;
            if (p > one_q16)
                p = one_q16;
            pos = p * n + half_q16;
            idx = pos >>> 16;
            if (idx > n - 1)
                idx = n - 1;
            if (idx < 1)
                idx = 1;
            base = idx <<< 16;
            if (pos <= base)
                frac = 0;
            else if (pos - base > one_q16)
                frac = one_q16;
            else
                frac = pos - base;
            lo = sorted_vals[idx - 1];
            hi = sorted_vals[idx];
            sum = (one_q16 - frac) * lo + frac * hi;
            return VALUE_W'((sum + half_q16) >>> 16);
        endfunction

        // Accepted input transfer: insert in order, or drop when the store is full.
        function void load_sample(logic signed [VALUE_W-1:0] v, bit last);
            int unsigned k;
            percentile_result_t res;
            if (held_count < STORE_DEPTH)
            begin
                k = held_count;
                while (k > 0 && sorted_vals[k - 1] > v)
                begin
                    sorted_vals[k] = sorted_vals[k - 1];
                    k--;
                end
                sorted_vals[k] = v;
                held_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (last)
            begin
                res.value = interpolate();
                res.dropped = dropped;
                pending_percentiles.push_back(res);
                if (dropped)
                    overflow_sets++;
                held_count = 0;
                dropped = 1'b0;
            end
        endfunction

        // Accepted output transfer: compare with the oldest expected percentile.
        function void match_percentile(logic [VALUE_W-1:0] value, logic flag);
            percentile_result_t exp_res;
            if (pending_percentiles.size() == 0)
            begin
                $display("%0t: unexpected result value %h flag %b", $time, value, flag);
                mismatches++;
                return;
            end
            exp_res = pending_percentiles.pop_front();
            sets_checked++;
            if (value !== exp_res.value)
            begin
                $display("%0t: percentile mismatch, expected %h actual %h",
                         $time, exp_res.value, value);
                mismatches++;
            end
            if (flag !== exp_res.dropped)
            begin
                $display("%0t: overflow flag mismatch, expected %b actual %b",
                         $time, exp_res.dropped, flag);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [FRAC_W-1:0]  cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata = '0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;

    percentile_checker_t checker_h = new();

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          rx_hold_request = 0;
    int unsigned samples_sent = 0;
    int unsigned samples_accepted = 0;
    int unsigned settings_used = 1;
    int          quiet_cycles = 0;

    percentile_interpolated_select #(
        .MAX_VALUES(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record every transfer on both streams at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                checker_h.load_sample(s_axis_tdata, s_axis_tlast);
                samples_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
                checker_h.match_percentile(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog on cycles with no transfer on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, checker_h.pending_percentiles.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                m_axis_tready <= 1'b0;
                hold = rx_hold_request;
                rx_hold_request = 0;
                repeat (hold) @(negedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Offer one value and wait for its transfer; may idle afterwards.
    task automatic send_item(input logic [VALUE_W-1:0] value, input bit last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // Send a whole set; the final value carries tlast.
    task automatic send_set(input int len, input value_mix_t mix);
        logic [VALUE_W-1:0] value;
        int v;
        for (int i = 0; i < len; i++)
        begin
            case (mix)
                MIX_WIDE: value = $urandom;
                MIX_CLUSTERED:
                begin
                    v = int'($urandom_range(0, 6)) - 3;
                    value = v * 65536 + ($urandom_range(0, 1) ? 32768 : 0);
                end
                MIX_MODERATE:
                begin
                    v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                    value = v;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: value = 32'h8000_0000;
                        1: value = 32'h7FFF_FFFF;
                        2: value = 32'h0000_0000;
                        default: value = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            send_item(value, i == len - 1);
        end
    endtask

    // Drop valid, let every expected result drain, then wait out the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (checker_h.pending_percentiles.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the percentile fraction while the block is idle.
    task automatic write_fraction(input logic [FRAC_W-1:0] f);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= f;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        checker_h.set_fraction(f);
        settings_used++;
        @(negedge clk);
    endtask

    // Random sets until the item budget is spent; mostly short sets.
    task automatic run_random_sets(input int unsigned budget);
        int unsigned stop_at;
        int unsigned r;
        int len;
        value_mix_t mix;
        stop_at = samples_sent + budget;
        while (samples_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(1, 8);
            else if (r < 90)
                len = $urandom_range(9, 24);
            else if (r < 98)
                len = $urandom_range(25, 63);
            else
                len = $urandom_range(64, 70);
            mix = value_mix_t'($urandom_range(0, 3));
            send_set(len, mix);
        end
    endtask

    initial
    begin
        logic [FRAC_W-1:0] fractions [10];
        fractions = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd65535,
                      17'd98304, 17'd16384, 17'd0, 17'd0, 17'd49152};
        fractions[7] = FRAC_W'($urandom_range(0, 65536));
        fractions[8] = FRAC_W'($urandom_range(0, 131071));

        // Hold reset, then release it.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sets at the reset fraction of one half.
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b1);
        for (int i = 3; i >= -1; i--)
            send_item(i * 65536, i == -1);
        // Ties between neighbors round toward plus infinity.
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        settle();

        // Random phases, one per fraction setting.
        foreach (fractions[i])
        begin
            write_fraction(fractions[i]);
            if (i == 6)
            begin
                // Full store, one dropped final value, and several dropped.
                send_set(STORE_DEPTH, MIX_WIDE);
                send_set(STORE_DEPTH + 1, MIX_MODERATE);
                send_set(STORE_DEPTH + 6, MIX_CLUSTERED);
            end
            run_random_sets(150);
            settle();
        end

        // Receiver holds off while single-value sets keep coming.
        tx_idle_en = 1'b0;
        rx_hold_request = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_set(1, MIX_WIDE);
        settle();

        // Final stretch with no idling on either side.
        write_fraction(FRAC_HALF);
        rx_idle_en = 1'b0;
        run_random_sets(200);
        settle();

        $display("Checked %0d percentile results from %0d samples over %0d fraction settings;",
                 checker_h.sets_checked, samples_accepted, settings_used);
        $display("%0d sets overflowed the %0d-entry store.",
                 checker_h.overflow_sets, STORE_DEPTH);
        if (checker_h.mismatches == 0 && checker_h.pending_percentiles.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
